FILE: design/nkct_pkg.sv
// shared types and constants of the name-keyed contact table
`default_nettype none
package nkct_pkg;

   // table capacity and derived widths
   localparam int DEPTH   = 32;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = 7;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int PHONE_W = 31;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

   // 20-byte name, byte 0 most significant, compares as one unsigned word
   typedef struct packed {
      logic [63:0] high;
      logic [63:0] mid;
      logic [31:0] low;
   } name_type;

   // one stored record
   typedef struct packed {
      name_type             name;
      logic [PHONE_W-1:0]   phone;
   } rec_type;

   // record store write request
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rec_type          data;
   } mem_wr_type;

   // record store read request
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

endpackage
`default_nettype wire

FILE: design/name_keyed_contact_table.sv
// top level of the name-keyed contact table: command sequencer and result register
//
//   channel | direction | transfer when        | payload
//   req     | in        | req_valid & ready    | command, key_high/mid/low, phone_in
//   rsp     | out       | rsp_valid & ready    | status, phone_out, out_*, fill, last
//
// add and unknown commands go straight to the result; look up searches the records,
// remove searches up to the hit, then shifts the rest; list gives one result
// per cycle while the consumer keeps up; sort runs an insertion sort; their pace is
// set by the record store, which has one read and one write port.
// reset clears the state, the record count and the result valid flag; no clearing pass runs over the store.
// a new command is taken while the previous result still waits in the output
// register; a stalled consumer holds the sequencer only when it has a result to hand over.
`default_nettype none
module name_keyed_contact_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_command,
   input  wire  [63:0] req_key_high,
   input  wire  [63:0] req_key_mid,
   input  wire  [31:0] req_key_low,
   input  wire  [30:0] req_phone_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [30:0] rsp_phone_out,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_mid,
   output logic [31:0] rsp_out_low,
   output logic [6:0]  rsp_fill,
   output logic        rsp_last
);

   localparam int IDX_W = nkct_pkg::IDX_W;
   localparam int CNT_W = nkct_pkg::CNT_W;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_RESP     = 8'b0000_0010,
      S_SCAN     = 8'b0000_0100,
      S_SHIFT    = 8'b0000_1000,
      S_LIST     = 8'b0001_0000,
      S_SORT_T   = 8'b0010_0000,
      S_SORT_CMP = 8'b0100_0000,
      S_SORT_PUT = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [nkct_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   nkct_pkg::name_type             key_ff, key_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [IDX_W-1:0]               i_ff, i_in;
   nkct_pkg::rec_type              rec_ff, rec_in;
   logic [nkct_pkg::STAT_W-1:0]    res_status_ff, res_status_in;
   logic                           res_rec_ff, res_rec_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nkct_pkg::STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   nkct_pkg::rec_type              rsp_rec_ff, rsp_rec_in;
   logic [CNT_W-1:0]               rsp_fill_ff, rsp_fill_in;
   logic                           rsp_last_ff, rsp_last_in;

   nkct_pkg::mem_wr_type           wr_req;
   nkct_pkg::mem_rd_type           rd_req;
   nkct_pkg::rec_type              rd_data;

   logic                           req_xfer;
   logic                           rsp_free;
   logic                           key_hit;
   logic                           sort_greater;
   logic                           idx_next_ok;
   logic                           idx_next2_ok;
   logic                           i_next_ok;

   nkct_store u_store (
      .clock   (clock),
      .wr      (wr_req),
      .rd      (rd_req),
      .rd_data (rd_data)
   );

   // handshake and loop bounds
   assign req_ready    = (state_ff == S_IDLE) && !reset;
   assign req_xfer     = req_valid && req_ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign key_hit      = (rd_data.name == key_ff);
   assign sort_greater = (rd_data.name > rec_ff.name);
   assign idx_next_ok  = (CNT_W'(idx_ff) + CNT_W'(1)) < count_ff;
   assign idx_next2_ok = (CNT_W'(idx_ff) + CNT_W'(2)) < count_ff;
   assign i_next_ok    = (CNT_W'(i_ff) + CNT_W'(1)) < count_ff;

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      i_in          = i_ff;
      rec_in        = rec_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;
      wr_req        = '0;
      rd_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in        = req_command;
               key_in        = '{high: req_key_high, mid: req_key_mid, low: req_key_low};
               res_rec_in    = 1'b0;
               res_status_in = nkct_pkg::STAT_OK;
               idx_in        = '0;
               state_in      = S_RESP;
               case (req_command)
                  nkct_pkg::CMD_ADD: begin
                     if (count_ff >= CNT_W'(nkct_pkg::DEPTH)) begin
                        res_status_in = nkct_pkg::STAT_FULL;
                     end else begin
                        wr_req.en            = 1'b1;
                        wr_req.addr          = count_ff[IDX_W-1:0];
                        wr_req.data.name     = '{high: req_key_high, mid: req_key_mid,
                                                 low: req_key_low};
                        wr_req.data.phone    = req_phone_in;
                        count_in             = count_ff + CNT_W'(1);
                     end
                  end
                  nkct_pkg::CMD_LOOKUP, nkct_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = nkct_pkg::STAT_EMPTY;
                     end else begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  nkct_pkg::CMD_LIST: begin
                     if (count_ff == '0) begin
                        res_status_in = nkct_pkg::STAT_EMPTY;
                     end else begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = '0;
                        state_in    = S_LIST;
                     end
                  end
                  nkct_pkg::CMD_SORT: begin
                     if (count_ff >= CNT_W'(2)) begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = IDX_W'(1);
                        i_in        = IDX_W'(1);
                        state_in    = S_SORT_T;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // one result into the output register
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff ? rec_ff : '0;
               rsp_fill_in   = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // linear search, one entry per cycle
         S_SCAN: begin
            if (key_hit) begin
               rec_in        = rd_data;
               res_rec_in    = 1'b1;
               res_status_in = nkct_pkg::STAT_OK;
               if (cmd_ff == nkct_pkg::CMD_REMOVE) begin
                  if (idx_next_ok) begin
                     rd_req.en   = 1'b1;
                     rd_req.addr = idx_ff + IDX_W'(1);
                     state_in    = S_SHIFT;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_RESP;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end else if (idx_next_ok) begin
               rd_req.en   = 1'b1;
               rd_req.addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
            end else begin
               res_status_in = nkct_pkg::STAT_NOT_FOUND;
               state_in      = S_RESP;
            end
         end

         // move later records down one place
         S_SHIFT: begin
            wr_req.en   = 1'b1;
            wr_req.addr = idx_ff;
            wr_req.data = rd_data;
            if (idx_next2_ok) begin
               rd_req.en   = 1'b1;
               rd_req.addr = idx_ff + IDX_W'(2);
               idx_in      = idx_ff + IDX_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end

         // stream records out as the consumer takes them
         S_LIST: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = nkct_pkg::STAT_OK;
               rsp_rec_in    = rd_data;
               rsp_fill_in   = count_ff;
               rsp_last_in   = !idx_next_ok;
               if (idx_next_ok) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = idx_ff + IDX_W'(1);
                  idx_in      = idx_ff + IDX_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // insertion sort: take record i, start comparing with i-1
         S_SORT_T: begin
            rec_in      = rd_data;
            idx_in      = i_ff;
            rd_req.en   = 1'b1;
            rd_req.addr = i_ff - IDX_W'(1);
            state_in    = S_SORT_CMP;
         end

         // rd_data holds record j-1, rec_ff the record being placed
         S_SORT_CMP: begin
            wr_req.en   = 1'b1;
            wr_req.addr = idx_ff;
            if (sort_greater) begin
               wr_req.data = rd_data;
               idx_in      = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = S_SORT_PUT;
               end else begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = idx_ff - IDX_W'(2);
               end
            end else begin
               wr_req.data = rec_ff;
               if (i_next_ok) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = i_ff + IDX_W'(1);
                  i_in        = i_ff + IDX_W'(1);
                  state_in    = S_SORT_T;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         // record goes to the front of the table
         S_SORT_PUT: begin
            wr_req.en   = 1'b1;
            wr_req.addr = '0;
            wr_req.data = rec_ff;
            if (i_next_ok) begin
               rd_req.en   = 1'b1;
               rd_req.addr = i_ff + IDX_W'(1);
               i_in        = i_ff + IDX_W'(1);
               state_in    = S_SORT_T;
            end else begin
               state_in = S_RESP;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      i_ff          <= i_in;
      rec_ff        <= rec_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_phone_out = rsp_rec_ff.phone;
   assign rsp_out_high  = rsp_rec_ff.name.high;
   assign rsp_out_mid   = rsp_rec_ff.name.mid;
   assign rsp_out_low   = rsp_rec_ff.name.low;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_last      = rsp_last_ff;

   // no read and write of the same entry in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_req.en && rd_req.en) |-> (wr_req.addr != rd_req.addr))
      else $error("read and write of the same entry in one cycle");

   // reads stay inside the filled part of the table
   a_read_in_fill: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |-> (CNT_W'(rd_req.addr) < count_ff))
      else $error("read beyond the record count");

   // count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(nkct_pkg::DEPTH))
      else $error("record count above capacity");

   // an add that fits grows the table by one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_command == nkct_pkg::CMD_ADD)
       && (count_ff < CNT_W'(nkct_pkg::DEPTH)))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow the table");

endmodule
`default_nettype wire

FILE: design/nkct_store.sv
// record store: one write port, one read port with registered read data
`default_nettype none
module nkct_store (
   input  wire                 clock,
   input  nkct_pkg::mem_wr_type wr,
   input  nkct_pkg::mem_rd_type rd,
   output nkct_pkg::rec_type    rd_data
);

   nkct_pkg::rec_type mem [nkct_pkg::DEPTH];
   nkct_pkg::rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sim/name_keyed_contact_table_tb.sv
// testbench for the name-keyed contact table: scripted and random command traffic
module name_keyed_contact_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 100;

   // codes the block accepts but does not act on
   localparam logic [nkct_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [nkct_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   // one result as the block should present it
   typedef struct packed {
      logic [nkct_pkg::STAT_W-1:0]  status;
      logic [nkct_pkg::PHONE_W-1:0] phone;
      nkct_pkg::name_type           name;
      logic [nkct_pkg::CNT_W-1:0]   fill;
      logic                         last;
   } contact_reply_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command  = '0;
   logic [63:0] req_key_high = '0;
   logic [63:0] req_key_mid  = '0;
   logic [31:0] req_key_low  = '0;
   logic [30:0] req_phone_in = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_phone_out;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_mid;
   logic [31:0] rsp_out_low;
   logic [6:0]  rsp_fill;
   logic        rsp_last;

   // behavioral copy of the contact book
   nkct_pkg::name_type           book_name  [nkct_pkg::DEPTH];
   logic [nkct_pkg::PHONE_W-1:0] book_phone [nkct_pkg::DEPTH];
   int                           book_count = 0;
   contact_reply_type            replies_due [$];
   contact_reply_type            reply_want;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int cycle_count        = 0;
   int mismatch_count     = 0;
   int items_sent         = 0;
   int replies_checked    = 0;
   int full_refusals      = 0;

   name_keyed_contact_table u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_key_high  (req_key_high),
      .req_key_mid   (req_key_mid),
      .req_key_low   (req_key_low),
      .req_phone_in  (req_phone_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_phone_out (rsp_phone_out),
      .rsp_out_high  (rsp_out_high),
      .rsp_out_mid   (rsp_out_mid),
      .rsp_out_low   (rsp_out_low),
      .rsp_fill      (rsp_fill),
      .rsp_last      (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, replies_due.size());
         $display("[name_keyed_contact_table] ERROR");
         $finish;
      end
   end

   // result consumer with random back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d on %s: got %0h, expected %0h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic void push_reply(logic [nkct_pkg::STAT_W-1:0] status,
                                      nkct_pkg::name_type name,
                                      logic [nkct_pkg::PHONE_W-1:0] phone, logic last);
      contact_reply_type r;
      r.status = status;
      r.phone  = phone;
      r.name   = name;
      r.fill   = nkct_pkg::CNT_W'(book_count);
      r.last   = last;
      replies_due.push_back(r);
   endfunction

   // index of the first record with exactly this name, or -1
   function automatic int find_contact(nkct_pkg::name_type key);
      for (int i = 0; i < book_count; i++)
         if (book_name[i] == key) return i;
      return -1;
   endfunction

   // apply one accepted command to the book copy and queue its results
   function automatic void apply_contact_command(logic [nkct_pkg::CMD_W-1:0] cmd,
                                                 nkct_pkg::name_type key,
                                                 logic [nkct_pkg::PHONE_W-1:0] phone);
      int                           hit;
      int                           j;
      nkct_pkg::name_type           moved_name;
      logic [nkct_pkg::PHONE_W-1:0] moved_phone;
      case (cmd)
         nkct_pkg::CMD_ADD: begin
            if (book_count >= nkct_pkg::DEPTH) begin
               full_refusals++;
               push_reply(nkct_pkg::STAT_FULL, '0, '0, 1'b1);
            end else begin
               book_name[book_count]  = key;
               book_phone[book_count] = phone;
               book_count++;
               push_reply(nkct_pkg::STAT_OK, '0, '0, 1'b1);
            end
         end
         nkct_pkg::CMD_LOOKUP: begin
            hit = find_contact(key);
            if (book_count == 0) push_reply(nkct_pkg::STAT_EMPTY, '0, '0, 1'b1);
            else if (hit < 0) push_reply(nkct_pkg::STAT_NOT_FOUND, '0, '0, 1'b1);
            else push_reply(nkct_pkg::STAT_OK, book_name[hit], book_phone[hit], 1'b1);
         end
         nkct_pkg::CMD_REMOVE: begin
            hit = find_contact(key);
            if (book_count == 0) push_reply(nkct_pkg::STAT_EMPTY, '0, '0, 1'b1);
            else if (hit < 0) push_reply(nkct_pkg::STAT_NOT_FOUND, '0, '0, 1'b1);
            else begin
               moved_name  = book_name[hit];
               moved_phone = book_phone[hit];
               for (int i = hit; i + 1 < book_count; i++) begin
                  book_name[i]  = book_name[i+1];
                  book_phone[i] = book_phone[i+1];
               end
               book_count--;
               push_reply(nkct_pkg::STAT_OK, moved_name, moved_phone, 1'b1);
            end
         end
         nkct_pkg::CMD_LIST: begin
            if (book_count == 0) push_reply(nkct_pkg::STAT_EMPTY, '0, '0, 1'b1);
            for (int i = 0; i < book_count; i++)
               push_reply(nkct_pkg::STAT_OK, book_name[i], book_phone[i],
                          i == book_count - 1);
         end
         nkct_pkg::CMD_SORT: begin
            // stable insertion sort, ascending by the 160-bit name
            for (int i = 1; i < book_count; i++) begin
               moved_name  = book_name[i];
               moved_phone = book_phone[i];
               j = i;
               while (j > 0 && book_name[j-1] > moved_name) begin
                  book_name[j]  = book_name[j-1];
                  book_phone[j] = book_phone[j-1];
                  j--;
               end
               book_name[j]  = moved_name;
               book_phone[j] = moved_phone;
            end
            push_reply(nkct_pkg::STAT_OK, '0, '0, 1'b1);
         end
         default: push_reply(nkct_pkg::STAT_OK, '0, '0, 1'b1);
      endcase
   endfunction

   // check every result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            report_mismatch("result with none expected, status", 64'(rsp_status), 64'd0);
         end else begin
            reply_want = replies_due.pop_front();
            replies_checked++;
            if (rsp_status !== reply_want.status)
               report_mismatch("status", 64'(rsp_status), 64'(reply_want.status));
            if (rsp_phone_out !== reply_want.phone)
               report_mismatch("phone_out", 64'(rsp_phone_out), 64'(reply_want.phone));
            if (rsp_out_high !== reply_want.name.high)
               report_mismatch("out_high", rsp_out_high, reply_want.name.high);
            if (rsp_out_mid !== reply_want.name.mid)
               report_mismatch("out_mid", rsp_out_mid, reply_want.name.mid);
            if (rsp_out_low !== reply_want.name.low)
               report_mismatch("out_low", 64'(rsp_out_low), 64'(reply_want.name.low));
            if (rsp_fill !== reply_want.fill)
               report_mismatch("fill", 64'(rsp_fill), 64'(reply_want.fill));
            if (rsp_last !== reply_want.last)
               report_mismatch("last", 64'(rsp_last), 64'(reply_want.last));
         end
      end
   end

   // one command transfer; entered and left at a falling edge
   task automatic send_item(logic [nkct_pkg::CMD_W-1:0] cmd, nkct_pkg::name_type key,
                            logic [nkct_pkg::PHONE_W-1:0] phone);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_key_high <= key.high;
      req_key_mid  <= key.mid;
      req_key_low  <= key.low;
      req_phone_in <= phone;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_contact_command(cmd, key, phone);
      items_sent++;
      @(negedge clock);
   endtask

   // hold off new commands until every queued result has been seen
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic nkct_pkg::name_type text_name(string text);
      logic [159:0] bits;
      bits = '0;
      for (int i = 0; i < text.len() && i < 20; i++) bits[159-8*i -: 8] = text[i];
      return bits;
   endfunction

   // half of the names short, from a tiny alphabet, so duplicates and ties are common
   function automatic nkct_pkg::name_type random_name();
      logic [159:0] bits;
      int           len;
      int           mode;
      bits = '0;
      mode = $urandom_range(9);
      if (mode == 2) begin
         bits = '0;
      end else if (mode == 3) begin
         bits = '1;
      end else if (mode == 4 && book_count > 0) begin
         // near miss: one bit away from a stored name
         bits = book_name[$urandom_range(book_count - 1)];
         bits[$urandom_range(159)] ^= 1'b1;
      end else if (mode <= 4) begin
         bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) bits[159-8*i -: 8] = 8'h61 + 8'($urandom_range(3));
      end
      return bits;
   endfunction

   // key for look up or remove: usually a stored name
   function automatic nkct_pkg::name_type pick_key();
      if (book_count > 0 && $urandom_range(99) < 65)
         return book_name[$urandom_range(book_count - 1)];
      return random_name();
   endfunction

   // commands on an empty table
   task automatic test_empty_table();
      send_item(nkct_pkg::CMD_LOOKUP, '0, '0);
      send_item(nkct_pkg::CMD_REMOVE, '1, '1);
      send_item(nkct_pkg::CMD_LIST, text_name("nobody"), '0);
      send_item(nkct_pkg::CMD_SORT, '0, '0);
   endtask

   // extremes, duplicates, hits and misses, list and sort
   task automatic test_basic_commands();
      send_item(nkct_pkg::CMD_ADD, '1, '1);
      send_item(nkct_pkg::CMD_ADD, '0, '0);
      send_item(nkct_pkg::CMD_ADD, text_name("bob"), nkct_pkg::PHONE_W'(5551234));
      send_item(nkct_pkg::CMD_ADD, text_name("bob"), nkct_pkg::PHONE_W'(5559876));
      send_item(nkct_pkg::CMD_LOOKUP, text_name("bob"), '0);
      send_item(nkct_pkg::CMD_LOOKUP, text_name("carol"), '0);
      send_item(nkct_pkg::CMD_REMOVE, text_name("bob"), '0);
      send_item(nkct_pkg::CMD_LOOKUP, text_name("bob"), '0);
      send_item(nkct_pkg::CMD_REMOVE, text_name("carol"), '0);
      send_item(nkct_pkg::CMD_LIST, '0, '0);
      send_item(nkct_pkg::CMD_SORT, '0, '0);
      send_item(nkct_pkg::CMD_LIST, '0, '0);
   endtask

   // names equal up to the terminator but differing in the padding
   task automatic test_exact_match();
      nkct_pkg::name_type tail_name;
      nkct_pkg::name_type near_name;
      tail_name = text_name("al");
      tail_name.high[63-8*5 -: 8] = 8'h7a;
      near_name = tail_name;
      near_name.low[0] = 1'b1;
      send_item(nkct_pkg::CMD_ADD, tail_name, nkct_pkg::PHONE_W'(42));
      send_item(nkct_pkg::CMD_LOOKUP, text_name("al"), '0);
      send_item(nkct_pkg::CMD_LOOKUP, near_name, '0);
      send_item(nkct_pkg::CMD_LOOKUP, tail_name, '0);
   endtask

   // codes with no defined action
   task automatic test_unknown_commands();
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
         send_item(nkct_pkg::CMD_W'(c), text_name("bob"), '1);
   endtask

   // fill to capacity, refuse adds, list and sort, then empty the table again
   task automatic test_capacity();
      while (book_count < nkct_pkg::DEPTH)
         send_item(nkct_pkg::CMD_ADD, random_name(), nkct_pkg::PHONE_W'($urandom));
      send_item(nkct_pkg::CMD_ADD, random_name(), nkct_pkg::PHONE_W'($urandom));
      send_item(nkct_pkg::CMD_ADD, pick_key(), nkct_pkg::PHONE_W'($urandom));
      send_item(nkct_pkg::CMD_LIST, '0, '0);
      send_item(nkct_pkg::CMD_SORT, '0, '0);
      send_item(nkct_pkg::CMD_LIST, '0, '0);
      send_item(nkct_pkg::CMD_LOOKUP, pick_key(), '0);
      while (book_count > 0)
         send_item(nkct_pkg::CMD_REMOVE, pick_key(), nkct_pkg::PHONE_W'($urandom));
   endtask

   // random mix, steering the fill level toward the middle of the range
   task automatic test_random_traffic(int count);
      int                         pick;
      int                         add_share;
      logic [nkct_pkg::CMD_W-1:0] cmd;
      nkct_pkg::name_type         key;
      repeat (count) begin
         add_share = (book_count < 6) ? 55 : (book_count > 26) ? 20 : 34;
         pick = $urandom_range(99);
         if (pick < add_share) cmd = nkct_pkg::CMD_ADD;
         else if (pick < add_share + 20) cmd = nkct_pkg::CMD_LOOKUP;
         else if (pick < add_share + 40) cmd = nkct_pkg::CMD_REMOVE;
         else if (pick < add_share + 48) cmd = nkct_pkg::CMD_LIST;
         else if (pick < add_share + 56) cmd = nkct_pkg::CMD_SORT;
         else if (pick < add_share + 59)
            cmd = nkct_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
         else cmd = nkct_pkg::CMD_LOOKUP;
         if (cmd == nkct_pkg::CMD_ADD)
            key = ($urandom_range(4) == 0) ? pick_key() : random_name();
         else key = pick_key();
         send_item(cmd, key, nkct_pkg::PHONE_W'($urandom));
      end
   endtask

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_basic_commands();
      test_exact_match();
      test_unknown_commands();
      wait_for_replies();

      test_capacity();
      wait_for_replies();

      // handshake mixes: free running, slow sender, slow consumer, light on both
      test_random_traffic(90);
      wait_for_replies();
      sender_idle_pct = 87;
      test_random_traffic(90);
      wait_for_replies();
      sender_idle_pct    = 0;
      receiver_stall_pct = 87;
      test_random_traffic(90);
      wait_for_replies();
      sender_idle_pct    = 13;
      receiver_stall_pct = 13;
      test_random_traffic(90);

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d commands: empty and full table, duplicates, padding-only name ",
               items_sent, "differences and sorts under four handshake mixes");
      $display("checked %0d results including %0d table-full refusals, %0d mismatches",
               replies_checked, full_refusals, mismatch_count);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("[name_keyed_contact_table] OK");
      end else begin
         $display("[name_keyed_contact_table] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/nkct_pkg.sv
design/nkct_store.sv
design/name_keyed_contact_table.sv
sim/name_keyed_contact_table_tb.sv
